>>> rtl/xml_entity_unescape_core_macros.svh
// ----------------------------------------------------------------------------
// XML entity decoder assertion macros
// Shorthand for the clocked, reset-gated properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef XML_ENTITY_UNESCAPE_CORE_MACROS_SVH
`define XML_ENTITY_UNESCAPE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define XEU_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define XEU_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/xeu_pkg.sv
// ----------------------------------------------------------------------------
// xeu_pkg
// Shared types, character codes and helpers of the XML entity decoder.
// ----------------------------------------------------------------------------
package xeu_pkg;

    typedef logic [7:0] byte_t;

    // Longest entity name accepted; the name counter holds up to 31.
    localparam int MAX_NAME   = 16;
    localparam int NAME_LEN_W = 5;
    // Only the first four name bytes are kept; that covers every known name.
    localparam int HEAD_DEPTH = 4;
    localparam int HEAD_IDX_W = 2;

    localparam byte_t CH_AMP   = 8'h26; // &
    localparam byte_t CH_SEMI  = 8'h3B; // ;
    localparam byte_t CH_LT    = 8'h3C; // <
    localparam byte_t CH_GT    = 8'h3E; // >
    localparam byte_t CH_APOS  = 8'h27; // '
    localparam byte_t CH_QUOT  = 8'h22; // "
    localparam byte_t CH_HASH  = 8'h23; // #
    localparam byte_t CH_LOW_A = 8'h61;
    localparam byte_t CH_LOW_G = 8'h67;
    localparam byte_t CH_LOW_L = 8'h6C;
    localparam byte_t CH_LOW_M = 8'h6D;
    localparam byte_t CH_LOW_O = 8'h6F;
    localparam byte_t CH_LOW_P = 8'h70;
    localparam byte_t CH_LOW_Q = 8'h71;
    localparam byte_t CH_LOW_S = 8'h73;
    localparam byte_t CH_LOW_T = 8'h74;
    localparam byte_t CH_LOW_U = 8'h75;
    localparam byte_t CH_LOW_X = 8'h78;

    // One decoded result.
    typedef struct packed {
        logic  ch_valid;
        byte_t ch;
        logic  str_end;
        logic  str_error;
    } xeu_result_t;

    // {is_digit, value} for one hex digit character.
    function automatic logic [4:0] hex_digit(input byte_t c);
        logic [4:0] res;
        res = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            res = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return res;
    endfunction

endpackage

>>> rtl/xeu_in_if.sv
// ----------------------------------------------------------------------------
// xeu_in_if
// Input channel: one text byte per item with an end-of-string mark.
// ----------------------------------------------------------------------------
interface xeu_in_if;
    import xeu_pkg::*;

    logic  valid;
    logic  ready;
    byte_t in_byte;
    logic  in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

>>> rtl/xeu_out_if.sv
// ----------------------------------------------------------------------------
// xeu_out_if
// Output channel: one decoded result per item.
// ----------------------------------------------------------------------------
interface xeu_out_if;
    import xeu_pkg::*;

    logic  valid;
    logic  ready;
    logic  out_valid;
    byte_t out_char;
    logic  out_end;
    logic  out_error;

    modport source (output valid, output out_valid, output out_char, output out_end,
                    output out_error, input ready);
    modport sink   (input valid, input out_valid, input out_char, input out_end,
                    input out_error, output ready);
endinterface

>>> rtl/xml_entity_unescape_core.sv
// ----------------------------------------------------------------------------
// xml_entity_unescape_core
// Streaming XML entity reference decoder, one text byte per item.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                    handshake
//  text_in   in   in_byte[7:0], in_last                      valid/ready
//  text_out  out  out_valid, out_char[7:0], out_end,         valid/ready
//                 out_error
//
//  One item in per cycle unless text_out stalls, one result per item, on
//  text_out next cycle. Throughput is set by the single result register.
//  Reset (rst_n low, async) clears the parser state and empties the result
//  register. A stalled text_out holds its result; text_in.ready stays high
//  while the held result is being taken, so no bubble is lost.
// ----------------------------------------------------------------------------
module xml_entity_unescape_core #(
    parameter int MAX_NAME = xeu_pkg::MAX_NAME
) (
    input  logic clk,
    input  logic rst_n,
    xeu_in_if.sink    text_in,
    xeu_out_if.source text_out
);
    import xeu_pkg::*;

    logic        accept;
    logic        load_ready;
    xeu_result_t dec_result;
    xeu_result_t out_result;

    // the parser advances only on an accepted byte
    assign accept        = text_in.valid && load_ready;
    assign text_in.ready = load_ready;

    // decode: parser state plus the combinational result of this byte
    xeu_decode #(
        .MAX_NAME (MAX_NAME)
    ) u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (text_in.in_byte),
        .in_last (text_in.in_last),
        .result  (dec_result)
    );

    // result register toward the consumer
    xeu_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (text_in.valid),
        .load_data  (dec_result),
        .load_ready (load_ready),
        .hold_valid (text_out.valid),
        .hold_data  (out_result),
        .hold_ready (text_out.ready)
    );

    assign text_out.out_valid = out_result.ch_valid;
    assign text_out.out_char  = out_result.ch;
    assign text_out.out_end   = out_result.str_end;
    assign text_out.out_error = out_result.str_error;

endmodule

>>> rtl/xeu_decode.sv
// ----------------------------------------------------------------------------
// xeu_decode
// Entity parser state and the per-byte decode of one result.
// ----------------------------------------------------------------------------
module xeu_decode #(
    parameter int MAX_NAME = xeu_pkg::MAX_NAME
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  xeu_pkg::byte_t       in_byte,
    input  logic                 in_last,
    output xeu_pkg::xeu_result_t result
);
    import xeu_pkg::*;

    logic                  inside_reg,  inside_next;
    logic [NAME_LEN_W-1:0] len_reg,     len_next;
    byte_t                 hex_reg,     hex_next;
    logic                  stopped_reg, stopped_next;
    logic                  error_reg,   error_next;
    byte_t                 head_reg  [HEAD_DEPTH];
    byte_t                 head_next [HEAD_DEPTH];

    logic       hex_prefix;
    logic       is_amp, is_lt, is_gt, is_apos, is_quot;
    logic [4:0] digit;
    logic       ch_valid;
    byte_t      ch;

    assign hex_prefix = (len_reg >= NAME_LEN_W'(2)) && (head_reg[0] == CH_HASH)
                        && (head_reg[1] == CH_LOW_X);
    assign is_amp  = (len_reg == NAME_LEN_W'(3)) && (head_reg[0] == CH_LOW_A)
                     && (head_reg[1] == CH_LOW_M) && (head_reg[2] == CH_LOW_P);
    assign is_lt   = (len_reg == NAME_LEN_W'(2)) && (head_reg[0] == CH_LOW_L)
                     && (head_reg[1] == CH_LOW_T);
    assign is_gt   = (len_reg == NAME_LEN_W'(2)) && (head_reg[0] == CH_LOW_G)
                     && (head_reg[1] == CH_LOW_T);
    assign is_apos = (len_reg == NAME_LEN_W'(4)) && (head_reg[0] == CH_LOW_A)
                     && (head_reg[1] == CH_LOW_P) && (head_reg[2] == CH_LOW_O)
                     && (head_reg[3] == CH_LOW_S);
    assign is_quot = (len_reg == NAME_LEN_W'(4)) && (head_reg[0] == CH_LOW_Q)
                     && (head_reg[1] == CH_LOW_U) && (head_reg[2] == CH_LOW_O)
                     && (head_reg[3] == CH_LOW_T);
    assign digit   = hex_digit(in_byte);

    always_comb
    begin
        inside_next  = inside_reg;
        len_next     = len_reg;
        hex_next     = hex_reg;
        stopped_next = stopped_reg;
        error_next   = error_reg;
        head_next    = head_reg;
        ch_valid     = 1'b0;
        ch           = 8'd0;

        if (!error_reg)
        begin
            if (!inside_reg)
            begin
                if (in_byte == CH_AMP)
                begin
                    inside_next  = 1'b1;
                    len_next     = '0;
                    hex_next     = 8'd0;
                    stopped_next = 1'b0;
                end
                else
                begin
                    ch_valid = 1'b1;
                    ch       = in_byte;
                end
            end
            else if (in_byte == CH_SEMI)
            begin
                inside_next = 1'b0;
                if (is_amp)
                begin
                    ch_valid = 1'b1;
                    ch       = CH_AMP;
                end
                else if (is_lt)
                begin
                    ch_valid = 1'b1;
                    ch       = CH_LT;
                end
                else if (is_gt)
                begin
                    ch_valid = 1'b1;
                    ch       = CH_GT;
                end
                else if (is_apos)
                begin
                    ch_valid = 1'b1;
                    ch       = CH_APOS;
                end
                else if (is_quot)
                begin
                    ch_valid = 1'b1;
                    ch       = CH_QUOT;
                end
                else if (hex_prefix)
                begin
                    // zero value gives no character
                    ch_valid = (hex_reg != 8'd0);
                    ch       = hex_reg;
                end
                else
                begin
                    error_next = 1'b1;
                end
            end
            else if (len_reg >= NAME_LEN_W'(MAX_NAME))
            begin
                error_next = 1'b1;
            end
            else
            begin
                if (hex_prefix && !stopped_reg)
                begin
                    if (digit[4])
                    begin
                        hex_next = {hex_reg[3:0], digit[3:0]};
                    end
                    else
                    begin
                        stopped_next = 1'b1;
                    end
                end
                if (len_reg < NAME_LEN_W'(HEAD_DEPTH))
                begin
                    head_next[len_reg[HEAD_IDX_W-1:0]] = in_byte;
                end
                len_next = len_reg + NAME_LEN_W'(1);
            end
            if (in_last && inside_next)
            begin
                error_next = 1'b1;
            end
        end

        if (error_next)
        begin
            ch_valid = 1'b0;
            ch       = 8'd0;
        end

        result.ch_valid  = ch_valid;
        result.ch        = ch;
        result.str_end   = in_last;
        result.str_error = in_last && error_next;

        // end of string returns all control state to idle
        if (in_last)
        begin
            inside_next  = 1'b0;
            len_next     = '0;
            hex_next     = 8'd0;
            stopped_next = 1'b0;
            error_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg  <= 1'b0;
            len_reg     <= '0;
            hex_reg     <= 8'd0;
            stopped_reg <= 1'b0;
            error_reg   <= 1'b0;
        end
        else if (accept)
        begin
            inside_reg  <= inside_next;
            len_reg     <= len_next;
            hex_reg     <= hex_next;
            stopped_reg <= stopped_next;
            error_reg   <= error_next;
        end
    end

    // name head: read only below the current length, so no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            head_reg <= head_next;
        end
    end

endmodule

>>> rtl/xeu_out_stage.sv
// ----------------------------------------------------------------------------
// xeu_out_stage
// Result register; refills in the same cycle the held item is taken.
// ----------------------------------------------------------------------------
module xeu_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load_valid,
    input  xeu_pkg::xeu_result_t load_data,
    output logic                 load_ready,
    output logic                 hold_valid,
    output xeu_pkg::xeu_result_t hold_data,
    input  logic                 hold_ready
);
    import xeu_pkg::*;

    logic        valid_reg, valid_next;
    xeu_result_t data_reg;

    assign load_ready = !valid_reg || hold_ready;
    assign valid_next = (load_valid && load_ready) || (valid_reg && !hold_ready);
    assign hold_valid = valid_reg;
    assign hold_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready) begin
            data_reg <= load_data;
        end
    end

endmodule

>>> rtl/xeu_checker.sv
// ----------------------------------------------------------------------------
// xeu_checker
// Port-level checks of the entity decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "xml_entity_unescape_core_macros.svh"

module xeu_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid_ch,
    input logic                 out_ready,
    input logic                 out_valid,
    input xeu_pkg::byte_t       out_char,
    input logic                 out_end,
    input logic                 out_error
);
    import xeu_pkg::*;

    // error is only reported on the last result of a string
    `XEU_ASSERT_NOW(a_error_on_end, out_valid_ch && out_error, out_end, "out_error without out_end")

    // a malformed string emits no character on its end result
    `XEU_ASSERT_NOW(a_error_no_char, out_valid_ch && out_error, !out_valid && (out_char == 8'd0), "character with error")

    // every accepted byte shows a result on the next cycle
    `XEU_ASSERT_NEXT(a_accept_result, in_valid && in_ready, out_valid_ch, "accepted item gave no result")

    // stalled result holds
    `XEU_ASSERT_NEXT(a_out_hold, out_valid_ch && !out_ready, out_valid_ch && $stable(out_char) && $stable(out_end) && $stable(out_valid), "stalled result changed")

endmodule

bind xml_entity_unescape_core xeu_checker u_xeu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (text_in.valid),
    .in_ready     (text_in.ready),
    .out_valid_ch (text_out.valid),
    .out_ready    (text_out.ready),
    .out_valid    (text_out.out_valid),
    .out_char     (text_out.out_char),
    .out_end      (text_out.out_end),
    .out_error    (text_out.out_error)
);

>>> bench/xml_entity_unescape_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_entity_unescape_core_tb
// Self-checking bench for the XML entity decoder. Strings are built from
// plain bytes, known entities, hex references, unknown and over-long names
// and broken tails, then streamed with random idling on both channels. A
// behavioral decoder in the scoreboard predicts every result.
// ----------------------------------------------------------------------------
module xml_entity_unescape_core_tb;
    import xeu_pkg::*;

    // Characters the predictor and the string builder need beyond the package set.
    localparam byte_t CH_DIGIT_0 = 8'h30;
    localparam byte_t CH_DIGIT_9 = 8'h39;
    localparam byte_t CH_LOW_F   = 8'h66;
    localparam byte_t CH_UP_A    = 8'h41;
    localparam byte_t CH_UP_F    = 8'h46;
    localparam byte_t CH_UP_X    = 8'h58;

    localparam int ITEMS_PER_PHASE = 425;
    localparam int IDLE_LIMIT      = 4000; // cycles without any handshake
    localparam int DRAIN_CYCLES    = 10;
    localparam int MAX_LINES       = 40;   // mismatch lines printed at most

    // ------------------------------------------------------------------------
    // Scoreboard: behavioral decoder plus the queue of expected results.
    // ------------------------------------------------------------------------
    class char_decode_board;
        byte_t                 name_head[HEAD_DEPTH];
        logic [NAME_LEN_W-1:0] name_len;
        logic                  in_entity;
        logic                  hex_done;
        logic                  err_sticky;
        byte_t                 hex_acc;
        xeu_result_t           expected_chars[$];
        int                    mismatches;

        function new();
            clear_state();
            mismatches = 0;
        endfunction

        function void clear_state();
            in_entity  = 1'b0;
            name_len   = '0;
            hex_acc    = '0;
            hex_done   = 1'b0;
            err_sticky = 1'b0;
            foreach (name_head[i])
                name_head[i] = '0;
        endfunction

        // Head compare; only entries below name_len are ever looked at.
        function bit name_is(int len, byte_t w0, byte_t w1, byte_t w2, byte_t w3);
            byte_t w[HEAD_DEPTH];
            w = '{w0, w1, w2, w3};
            if (name_len != len)
                return 0;
            for (int i = 0; i < len; i++)
                if (name_head[i] != w[i])
                    return 0;
            return 1;
        endfunction

        function bit hex_named();
            return name_len >= 2 && name_head[0] == CH_HASH && name_head[1] == CH_LOW_X;
        endfunction

        // -1 for a non-digit.
        function int digit_value(byte_t c);
            if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
                return int'(c - CH_DIGIT_0);
            if (c >= CH_LOW_A && c <= CH_LOW_F)
                return int'(c - CH_LOW_A) + 10;
            if (c >= CH_UP_A && c <= CH_UP_F)
                return int'(c - CH_UP_A) + 10;
            return -1;
        endfunction

        // Accepted input: advance the decoder, queue the result it gives.
        function void note_input(byte_t c, logic last);
            xeu_result_t res;
            logic        emit;
            byte_t       ch;
            int          d;
            emit = 1'b0;
            ch   = '0;
            if (!err_sticky) begin
                if (!in_entity) begin
                    if (c == CH_AMP) begin
                        in_entity = 1'b1;
                        name_len  = '0;
                        hex_acc   = '0;
                        hex_done  = 1'b0;
                    end
                    else begin
                        emit = 1'b1;
                        ch   = c;
                    end
                end
                else if (c == CH_SEMI) begin
                    in_entity = 1'b0;
                    if (name_is(3, CH_LOW_A, CH_LOW_M, CH_LOW_P, 8'h00)) begin
                        emit = 1'b1;
                        ch   = CH_AMP;
                    end
                    else if (name_is(2, CH_LOW_L, CH_LOW_T, 8'h00, 8'h00)) begin
                        emit = 1'b1;
                        ch   = CH_LT;
                    end
                    else if (name_is(2, CH_LOW_G, CH_LOW_T, 8'h00, 8'h00)) begin
                        emit = 1'b1;
                        ch   = CH_GT;
                    end
                    else if (name_is(4, CH_LOW_A, CH_LOW_P, CH_LOW_O, CH_LOW_S)) begin
                        emit = 1'b1;
                        ch   = CH_APOS;
                    end
                    else if (name_is(4, CH_LOW_Q, CH_LOW_U, CH_LOW_O, CH_LOW_T)) begin
                        emit = 1'b1;
                        ch   = CH_QUOT;
                    end
                    else if (hex_named()) begin
                        // zero value gives nothing
                        if (hex_acc != 0) begin
                            emit = 1'b1;
                            ch   = hex_acc;
                        end
                    end
                    else begin
                        err_sticky = 1'b1;
                    end
                end
                else if (name_len >= MAX_NAME) begin
                    err_sticky = 1'b1;
                end
                else begin
                    if (hex_named() && !hex_done) begin
                        d = digit_value(c);
                        if (d < 0)
                            hex_done = 1'b1;
                        else
                            hex_acc = {hex_acc[3:0], 4'(d)};
                    end
                    if (name_len < HEAD_DEPTH)
                        name_head[name_len[HEAD_IDX_W-1:0]] = c;
                    name_len = name_len + 1'b1;
                end
                if (last && in_entity)
                    err_sticky = 1'b1;
            end
            if (err_sticky) begin
                emit = 1'b0;
                ch   = '0;
            end
            res.ch_valid  = emit;
            res.ch        = ch;
            res.str_end   = last;
            res.str_error = last && err_sticky;
            expected_chars.push_back(res);
            if (last)
                clear_state();
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= MAX_LINES)
                $display("%0t ns: mismatch: %s", $realtime, msg);
        endtask

        task check_result(xeu_result_t got);
            xeu_result_t want;
            if (expected_chars.size() == 0) begin
                report($sformatf("result %h with nothing expected", got));
                return;
            end
            want = expected_chars.pop_front();
            if (got.ch_valid !== want.ch_valid)
                report($sformatf("out_valid %b, want %b", got.ch_valid, want.ch_valid));
            if (got.ch !== want.ch)
                report($sformatf("out_char %h, want %h", got.ch, want.ch));
            if (got.str_end !== want.str_end)
                report($sformatf("out_end %b, want %b", got.str_end, want.str_end));
            if (got.str_error !== want.str_error)
                report($sformatf("out_error %b, want %b", got.str_error, want.str_error));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels, block
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    xeu_in_if  text_in();
    xeu_out_if text_out();

    xml_entity_unescape_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_in),
        .text_out (text_out)
    );

    char_decode_board board = new();

    int          send_idle_pct;   // chance per item slot that the sender waits
    int          recv_stall_pct;  // chance per cycle that text_out.ready is low
    int          quiet_cycles;
    int          items_sent;
    xeu_result_t seen;

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge clk)
    begin
        text_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Both monitors and the watchdog. Reads right after the edge see the
    // values the block sampled, since everything here changes through NBAs.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (text_out.valid && text_out.ready) begin
                seen.ch_valid  = text_out.out_valid;
                seen.ch        = text_out.out_char;
                seen.str_end   = text_out.out_end;
                seen.str_error = text_out.out_error;
                board.check_result(seen);
            end
            if (text_in.valid && text_in.ready)
                board.note_input(text_in.in_byte, text_in.in_last);
        end
        if ((text_in.valid && text_in.ready) || (text_out.valid && text_out.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // String building
    // ------------------------------------------------------------------------
    function automatic void add_text(ref byte_t q[$], input string s);
        for (int i = 0; i < s.len(); i++)
            q.push_back(byte_t'(s[i]));
    endfunction

    // Random name byte that never closes the entity.
    function automatic byte_t name_byte();
        byte_t b;
        b = byte_t'($urandom_range(255));
        return (b == CH_SEMI) ? CH_LOW_X : b;
    endfunction

    function automatic byte_t hex_char();
        int v;
        v = $urandom_range(15);
        if (v < 10)
            return CH_DIGIT_0 + byte_t'(v);
        return ($urandom_range(1) ? CH_UP_A : CH_LOW_A) + byte_t'(v - 10);
    endfunction

    function automatic void add_hex_ref(ref byte_t q[$]);
        int n;
        q.push_back(CH_AMP);
        q.push_back(CH_HASH);
        // upper-case X is not a hex prefix
        q.push_back(($urandom_range(19) == 0) ? CH_UP_X : CH_LOW_X);
        n = ($urandom_range(9) == 0) ? $urandom_range(3, 7) : $urandom_range(0, 2);
        repeat (n) q.push_back(hex_char());
        if ($urandom_range(3) == 0) begin
            q.push_back(name_byte());
            repeat ($urandom_range(2)) q.push_back(hex_char());
        end
        q.push_back(CH_SEMI);
    endfunction

    function automatic void add_known_ref(ref byte_t q[$]);
        string known[5]  = '{"amp", "lt", "gt", "apos", "quot"};
        string nearby[5] = '{"am", "ltt", "Gt", "aposs", "quo"};
        q.push_back(CH_AMP);
        if ($urandom_range(9) < 8)
            add_text(q, known[$urandom_range(4)]);
        else
            add_text(q, nearby[$urandom_range(4)]);
        q.push_back(CH_SEMI);
    endfunction

    // Mostly well-formed strings with random content; some noise and
    // broken entities mixed in.
    function automatic void make_string(ref byte_t q[$]);
        int n;
        q.delete();
        if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(1, 8)) q.push_back(byte_t'($urandom_range(255)));
            return;
        end
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(11))
                0, 1, 2, 3: q.push_back(byte_t'($urandom_range(255)));
                4, 5:       add_known_ref(q);
                6, 7:       add_hex_ref(q);
                8:
                begin
                    // unknown name, possibly empty
                    q.push_back(CH_AMP);
                    repeat ($urandom_range(5)) q.push_back(name_byte());
                    q.push_back(CH_SEMI);
                end
                9:
                begin
                    // name length around the limit
                    q.push_back(CH_AMP);
                    n = $urandom_range(MAX_NAME - 2, MAX_NAME + 4);
                    repeat (n) q.push_back(CH_LOW_A + byte_t'($urandom_range(25)));
                    q.push_back(CH_SEMI);
                end
                10:
                begin
                    // '&' inside a name is just a name byte
                    q.push_back(CH_AMP);
                    q.push_back(CH_AMP);
                    add_text(q, "lt");
                    q.push_back(CH_SEMI);
                end
                default:
                begin
                    // entity left open; may run into the end of the string
                    q.push_back(CH_AMP);
                    repeat ($urandom_range(3)) q.push_back(name_byte());
                end
            endcase
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------------
    task automatic send_string(input byte_t q[$]);
        foreach (q[i]) begin
            while ($urandom_range(99) < send_idle_pct) begin
                text_in.valid <= 1'b0;
                @(posedge clk);
            end
            text_in.valid   <= 1'b1;
            text_in.in_byte <= q[i];
            text_in.in_last <= (i == q.size() - 1);
            do
                @(posedge clk);
            while (!text_in.ready);
            items_sent++;
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        byte_t q[$];
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        items_sent     = 0;
        while (items_sent < ITEMS_PER_PHASE) begin
            make_string(q);
            send_string(q);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        byte_t q[$];
        rst_n           = 1'b0;
        text_in.valid   = 1'b0;
        text_in.in_byte = '0;
        text_in.in_last = 1'b0;
        text_out.ready  = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        quiet_cycles    = 0;
        items_sent      = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings: byte extremes around a known entity.
        q = '{8'h00};
        add_text(q, "&lt;");
        q.push_back(8'hFF);
        send_string(q);
        // hex reference that emits a character
        q.delete();
        add_text(q, "&#x41;");
        send_string(q);
        // unknown name, then a byte dropped by the pending error
        q.delete();
        add_text(q, "&q;x");
        send_string(q);
        // string ending on an open '&'
        q.delete();
        add_text(q, "a&");
        send_string(q);
        // hex reference with no digits gives nothing
        q.delete();
        add_text(q, "&#x;");
        send_string(q);
        // empty name
        q.delete();
        add_text(q, "&;");
        send_string(q);

        // Random phases: free running, sender idling, receiver stalling, both.
        run_phase(0, 0);
        run_phase(53, 0);
        run_phase(0, 53);
        run_phase(6, 6);

        text_in.valid <= 1'b0;
        while (board.expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/xeu_pkg.sv
rtl/xeu_in_if.sv
rtl/xeu_out_if.sv
rtl/xeu_decode.sv
rtl/xeu_out_stage.sv
rtl/xml_entity_unescape_core.sv
rtl/xeu_checker.sv
bench/xml_entity_unescape_core_tb.sv
